// ===== rtl/core/gsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// gsmd_pkg
// Shared types and constants for the greedy syndrome matching decoder.
// ----------------------------------------------------------------------------
package gsmd_pkg;

    localparam int MASK_W    = 32;   // detector mask and syndrome width
    localparam int WORD_W    = 64;   // chosen-error map word width
    localparam int WNUM_W    = 6;    // word number field width
    localparam int WCNT_W    = 4;    // output word counter, up to 8 words
    localparam int CNT_W     = 13;   // wide enough for any row count compare
    localparam int PADDR_W   = 3;    // two registers at byte 0 and 4
    localparam int PDATA_W   = 32;
    localparam int DET_W     = 6;
    localparam int ROWS_W    = 9;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic REG_DETECTORS = 1'b0;
    localparam logic REG_ROWS      = 1'b1;

    localparam logic [DET_W-1:0]  DETECTORS_RESET = 6'd32;
    localparam logic [ROWS_W-1:0] ROWS_RESET      = 9'd256;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        row_number;
        logic [MASK_W-1:0] row_detector_mask;
        logic              row_flips_logical;
        logic [MASK_W-1:0] syndrome_bits;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] error_word;
        logic [WNUM_W-1:0] word_number;
        logic              flip_parity;
        logic              last_word;
    } res_t;

    typedef struct packed {
        logic              logical;
        logic [MASK_W-1:0] mask;
    } row_entry_t;

    typedef struct packed {
        logic [DET_W-1:0]  detectors_in_use;
        logic [ROWS_W-1:0] rows_in_use;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic we;
    } map_ctl_t;

endpackage

// ===== rtl/core/greedy_syndrome_matching_decoder.sv =====
// ----------------------------------------------------------------------------
// greedy_syndrome_matching_decoder
// Greedy matching decoder: loads parity rows, decodes a syndrome by walking
// active detectors and scanning the row memory, then streams the chosen-error
// map as 64-bit words with the logical flip.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                req (gsmd_pkg::req_t)
// result    out        result_valid, one cycle      result (gsmd_pkg::res_t)
// config    in         psel & penable & pwrite      pwdata at paddr 0 / 4
//
// A load request leaves busy low. A decode walks each detector below the
// detector count; each still-active detector scans the rows until a pair
// match (or all rows), and a chosen row, if any, is applied in ST_APPLY_RD
// and ST_APPLY_WR. Each output word is then read in ST_OUT_RD and strobed in
// ST_OUT_EMIT; the final word is strobed in the same cycle that busy drops.
// The row scan sets the busy time.
// Reset clears control state, the configuration and the map valid bits; the
// row memory holds no reset and needs no clearing pass.
// Results cannot be stalled: each word shows for exactly one cycle.
// ----------------------------------------------------------------------------
module greedy_syndrome_matching_decoder #(
    parameter int MAX_DETECTORS = 32,
    parameter int MAX_ROWS      = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gsmd_pkg::req_t               req,
    output logic                         result_valid,
    output gsmd_pkg::res_t               result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsmd_pkg::PADDR_W-1:0] paddr,
    input  logic [gsmd_pkg::PDATA_W-1:0] pwdata,
    output logic [gsmd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import gsmd_pkg::*;

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAP_WORDS = (MAX_ROWS + 63) / 64;
    localparam int MAP_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET,
        ST_ROW,
        ST_APPLY_RD,
        ST_APPLY_WR,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    cfg_t cfg;

    gsmd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    state_t            state_reg,       state_next;
    logic [DET_W-1:0]  cursor_reg,      cursor_next;
    logic [MASK_W-1:0] defects_reg,     defects_next;
    logic              parity_reg,      parity_next;
    logic [MASK_W-1:0] det_mask_reg,    det_mask_next;
    logic [DET_W-1:0]  ndet_reg,        ndet_next;
    logic [ROWS_W-1:0] nrows_reg,       nrows_next;
    logic [ROW_W-1:0]  cur_row_reg,     cur_row_next;
    logic              have_single_reg, have_single_next;
    logic [ROW_W-1:0]  single_row_reg,  single_row_next;
    logic              single_log_reg,  single_log_next;
    logic [ROW_W-1:0]  pick_row_reg,    pick_row_next;
    logic [MASK_W-1:0] pick_mask_reg,   pick_mask_next;
    logic              pick_log_reg,    pick_log_next;
    logic [WCNT_W-1:0] word_reg,        word_next;
    res_t              res_reg,         res_next;
    logic              res_valid_reg,   res_valid_next;

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    logic              row_we;
    logic [ROW_W-1:0]  row_raddr;
    row_entry_t        row_wdata;
    row_entry_t        row_rdata;

    map_ctl_t          map_ctl;
    logic [MAP_W-1:0]  map_raddr;
    logic [MAP_W-1:0]  pick_word;
    logic [WORD_W-1:0] map_wdata;
    logic [WORD_W-1:0] map_rword;

    assign row_wdata.logical = req.row_flips_logical;
    assign row_wdata.mask    = req.row_detector_mask;

    gsmd_row_store #(
        .DEPTH (MAX_ROWS),
        .AW    (ROW_W)
    ) u_rows (
        .clk   (clk),
        .we    (row_we),
        .waddr (ROW_W'(req.row_number)),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    gsmd_map_store #(
        .DEPTH (MAP_WORDS),
        .AW    (MAP_W)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (map_ctl),
        .waddr (pick_word),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rword (map_rword)
    );

    // ------------------------------------------------------------------------
    // Effective counts at decode start
    // ------------------------------------------------------------------------
    logic [DET_W-1:0]  ndet_eff;
    logic [DET_W-1:0]  ndet_scan;
    logic [ROWS_W-1:0] nrows_eff;
    logic [MASK_W-1:0] det_mask_calc;

    always_comb
    begin
        // Clamp the detector count; mask bits stop at 32 anyway
        ndet_eff  = (7'(cfg.detectors_in_use) > 7'(MAX_DETECTORS))
                    ? DET_W'(MAX_DETECTORS) : cfg.detectors_in_use;
        ndet_scan = (ndet_eff > DET_W'(MASK_W)) ? DET_W'(MASK_W) : ndet_eff;
        nrows_eff = (CNT_W'(cfg.rows_in_use) > CNT_W'(MAX_ROWS))
                    ? ROWS_W'(MAX_ROWS) : cfg.rows_in_use;
        for (int j = 0; j < MASK_W; j++)
        begin
            det_mask_calc[j] = (7'(j) < 7'(ndet_scan));
        end
    end

    // ------------------------------------------------------------------------
    // Row evaluation on the row just read
    // ------------------------------------------------------------------------
    logic [MASK_W-1:0] row_mask;
    logic [MASK_W-1:0] dbit;
    logic [MASK_W-1:0] other;
    logic              hit;
    logic              is_single;
    logic              pair_ok;
    logic              last_row;
    logic              single_take;
    logic [WCNT_W-1:0] words;
    logic              last_out;
    logic [WORD_W-1:0] out_word;

    always_comb
    begin
        row_mask    = row_rdata.mask & det_mask_reg;
        dbit        = MASK_W'(1) << cursor_reg[4:0];
        hit         = |(row_mask & dbit);
        other       = row_mask & ~dbit;
        is_single   = hit && (other == '0);
        // Exactly two detectors, and the partner is still active
        pair_ok     = hit && (other != '0) && ((other & (other - MASK_W'(1))) == '0)
                      && ((defects_reg & other) != '0);
        last_row    = (CNT_W'(cur_row_reg) == (CNT_W'(nrows_reg) - CNT_W'(1)));
        single_take = is_single && !have_single_reg;
        words       = WCNT_W'((CNT_W'(nrows_reg) + CNT_W'(63)) >> 6);
        last_out    = (nrows_reg == '0) || (word_reg == (words - WCNT_W'(1)));
        out_word    = (nrows_reg == '0) ? '0 : map_rword;
        // Trim the tail word to the row count
        if (last_out && (nrows_reg[5:0] != 6'd0))
        begin
            out_word = out_word & ((WORD_W'(1) << nrows_reg[5:0]) - WORD_W'(1));
        end
    end

    assign pick_word = MAP_W'(pick_row_reg >> 6);
    assign map_wdata = map_rword ^ (WORD_W'(1) << 6'(pick_row_reg));

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        defects_next     = defects_reg;
        parity_next      = parity_reg;
        det_mask_next    = det_mask_reg;
        ndet_next        = ndet_reg;
        nrows_next       = nrows_reg;
        cur_row_next     = cur_row_reg;
        have_single_next = have_single_reg;
        single_row_next  = single_row_reg;
        single_log_next  = single_log_reg;
        pick_row_next    = pick_row_reg;
        pick_mask_next   = pick_mask_reg;
        pick_log_next    = pick_log_reg;
        word_next        = word_reg;
        res_next         = res_reg;
        res_valid_next   = 1'b0;
        row_we           = 1'b0;
        row_raddr        = cur_row_reg + ROW_W'(1);
        map_ctl.clear    = 1'b0;
        map_ctl.we       = 1'b0;
        map_raddr        = pick_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == REQ_DECODE)
                    begin
                        defects_next  = req.syndrome_bits & det_mask_calc;
                        parity_next   = 1'b0;
                        cursor_next   = '0;
                        det_mask_next = det_mask_calc;
                        ndet_next     = ndet_scan;
                        nrows_next    = nrows_eff;
                        map_ctl.clear = 1'b1;
                        state_next    = ST_DET;
                    end
                    else
                    begin
                        // Drop loads beyond the store
                        row_we = (CNT_W'(req.row_number) < CNT_W'(MAX_ROWS));
                    end
                end
            end

            ST_DET:
            begin
                row_raddr = '0;
                if (cursor_reg >= ndet_reg)
                begin
                    word_next  = '0;
                    state_next = ST_OUT_RD;
                end
                else if (!defects_reg[cursor_reg[4:0]] || (nrows_reg == '0))
                begin
                    cursor_next = cursor_reg + DET_W'(1);
                end
                else
                begin
                    cur_row_next     = '0;
                    have_single_next = 1'b0;
                    state_next       = ST_ROW;
                end
            end

            ST_ROW:
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
                if (pair_ok)
                begin
                    pick_row_next  = cur_row_reg;
                    pick_mask_next = row_mask;
                    pick_log_next  = row_rdata.logical;
                    state_next     = ST_APPLY_RD;
                end
                else
                begin
                    if (single_take)
                    begin
                        have_single_next = 1'b1;
                        single_row_next  = cur_row_reg;
                        single_log_next  = row_rdata.logical;
                    end
                    if (last_row)
                    begin
                        if (have_single_reg || single_take)
                        begin
                            pick_row_next  = single_take ? cur_row_reg : single_row_reg;
                            pick_log_next  = single_take ? row_rdata.logical
                                                         : single_log_reg;
                            pick_mask_next = dbit;
                            state_next     = ST_APPLY_RD;
                        end
                        else
                        begin
                            // Unmatched defect stays active
                            cursor_next = cursor_reg + DET_W'(1);
                            state_next  = ST_DET;
                        end
                    end
                end
            end

            ST_APPLY_RD:
            begin
                defects_next = defects_reg ^ pick_mask_reg;
                parity_next  = parity_reg ^ pick_log_reg;
                state_next   = ST_APPLY_WR;
            end

            ST_APPLY_WR:
            begin
                map_ctl.we  = 1'b1;
                cursor_next = cursor_reg + DET_W'(1);
                state_next  = ST_DET;
            end

            ST_OUT_RD:
            begin
                map_raddr  = MAP_W'(word_reg);
                state_next = ST_OUT_EMIT;
            end

            ST_OUT_EMIT:
            begin
                map_raddr            = MAP_W'(word_reg);
                res_next.error_word  = out_word;
                res_next.word_number = WNUM_W'(word_reg);
                res_next.flip_parity = parity_reg;
                res_next.last_word   = last_out;
                res_valid_next       = 1'b1;
                if (last_out)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next  = word_reg + WCNT_W'(1);
                    state_next = ST_OUT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cursor_reg      <= '0;
            defects_reg     <= '0;
            parity_reg      <= 1'b0;
            have_single_reg <= 1'b0;
            word_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            defects_reg     <= defects_next;
            parity_reg      <= parity_next;
            have_single_reg <= have_single_next;
            word_reg        <= word_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        det_mask_reg   <= det_mask_next;
        ndet_reg       <= ndet_next;
        nrows_reg      <= nrows_next;
        cur_row_reg    <= cur_row_next;
        single_row_reg <= single_row_next;
        single_log_reg <= single_log_next;
        pick_row_reg   <= pick_row_next;
        pick_mask_reg  <= pick_mask_next;
        pick_log_reg   <= pick_log_next;
        res_reg        <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/core/gsmd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gsmd_cfg_regs
// APB configuration registers: detector count and row count.
// ----------------------------------------------------------------------------
module gsmd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gsmd_pkg::PADDR_W-1:0] paddr,
    input  logic [gsmd_pkg::PDATA_W-1:0] pwdata,
    output logic [gsmd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output gsmd_pkg::cfg_t               cfg
);
    import gsmd_pkg::*;

    logic [DET_W-1:0]  det_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_reg  <= DETECTORS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_DETECTORS: det_reg  <= pwdata[DET_W-1:0];
                REG_ROWS:      rows_reg <= pwdata[ROWS_W-1:0];
                default:       det_reg  <= det_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DETECTORS: prdata = PDATA_W'(det_reg);
            REG_ROWS:      prdata = PDATA_W'(rows_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.detectors_in_use = det_reg;
    assign cfg.rows_in_use      = rows_reg;

endmodule

// ===== rtl/core/gsmd_row_store.sv =====
// ----------------------------------------------------------------------------
// gsmd_row_store
// Parity row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gsmd_row_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  gsmd_pkg::row_entry_t wdata,
    input  logic [AW-1:0]        raddr,
    output gsmd_pkg::row_entry_t rdata
);
    import gsmd_pkg::*;

    row_entry_t mem [DEPTH];
    row_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gsmd_map_store.sv =====
// ----------------------------------------------------------------------------
// gsmd_map_store
// Chosen-error map memory in 64-bit words, with per-word valid bits so a
// decode start clears the whole map without a clearing pass.
// ----------------------------------------------------------------------------
module gsmd_map_store #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gsmd_pkg::map_ctl_t          ctl,
    input  logic [AW-1:0]               waddr,
    input  logic [gsmd_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [gsmd_pkg::WORD_W-1:0] rword
);
    import gsmd_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Invalid word reads as cleared
    assign rword = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/gsmd_checker.sv =====
// ----------------------------------------------------------------------------
// gsmd_checker
// Port-level checks on request acceptance and result streaming.
// ----------------------------------------------------------------------------
module gsmd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input gsmd_pkg::req_t req,
    input logic           result_valid,
    input gsmd_pkg::res_t result
);
    import gsmd_pkg::*;

    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.req_type == REQ_DECODE) |=> busy)
        else $error("decode request did not raise busy");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.req_type == REQ_LOAD) |=> !busy && !result_valid)
        else $error("load request produced activity");

    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_word |-> busy)
        else $error("idle before final word");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_word |-> !busy)
        else $error("still busy on final word");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a decode in progress");

endmodule

bind greedy_syndrome_matching_decoder gsmd_checker u_gsmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
);
